// ===== rtl/core/spc_pkg.sv =====
// Package for the stepper position controller: field widths, command and mode codes,
// and the constants derived from the motor's steps per revolution.
// No dependencies.
`timescale 1ns / 1ps

package spc_pkg;

    localparam int STEPS_PER_REV = 200;

    localparam int FUNC_W  = 4;
    localparam int ANGLE_W = 9;
    localparam int STEP_W  = 2;
    localparam int POS_W   = 16;
    localparam int WRAP_W  = 12;
    localparam int MODE_W  = 3;
    localparam int PEND_W  = 13;

    // Sweep limit and the half circle used to pick the shortest goto path.
    localparam int SPAN = STEPS_PER_REV / 4;
    localparam int HALF = STEPS_PER_REV / 2;

    // Home moves are clamped to this many steps either way.
    localparam int HOME_LIMIT = 2048;

    // Position modulo one revolution at the two ends of the 16-bit range,
    // used when the position rolls over.
    localparam int WRAP_AT_MIN = (((-32768) % STEPS_PER_REV) + STEPS_PER_REV) % STEPS_PER_REV;
    localparam int WRAP_AT_MAX = 32767 % STEPS_PER_REV;

    // Goto target: floor((angle * N + 180) / 360). The division by 360 is a
    // shift by three and then a multiply by the reciprocal of 45.
    localparam int TGT_X_MAX = ((1 << ANGLE_W) - 1) * STEPS_PER_REV + 180;
    localparam int X_W       = $clog2(TGT_X_MAX + 1);
    localparam int Y_W       = X_W - 3;
    localparam int DIV_K     = Y_W + 6;
    localparam int DIV_M     = ((1 << DIV_K) + 44) / 45;
    localparam int M_W       = $clog2(DIV_M + 1);
    localparam int PROD_W    = Y_W + M_W;
    localparam int Q_W       = X_W - 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK     = 4'd0,
        FUNC_SWEEP    = 4'd1,
        FUNC_STEP_CW  = 4'd2,
        FUNC_STEP_CCW = 4'd3,
        FUNC_RUN_CW   = 4'd4,
        FUNC_RUN_CCW  = 4'd5,
        FUNC_GOTO     = 4'd6,
        FUNC_HOME     = 4'd7,
        FUNC_ZERO     = 4'd8,
        FUNC_STOP     = 4'd9,
        FUNC_OFF      = 4'd10
    } t_func;

    typedef enum logic [MODE_W-1:0] {
        MODE_REST     = 3'd0,
        MODE_SCAN     = 3'd1,
        MODE_SPIN_CW  = 3'd2,
        MODE_SPIN_CCW = 3'd3,
        MODE_MOVE     = 3'd4
    } t_mode;

    typedef enum logic [STEP_W-1:0] {
        STEP_NONE = 2'd0,
        STEP_CW   = 2'd1,
        STEP_CCW  = 2'd2
    } t_step;

endpackage

// ===== rtl/core/spc_target.sv =====
// Two-stage goto target calculation: angle in degrees to a step index in one revolution.
// Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_target (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [spc_pkg::ANGLE_W-1:0]  i_angle,
    output logic [spc_pkg::WRAP_W-1:0]   o_target
);
    import spc_pkg::*;

    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    r_y;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q;
    logic [Q_W-1:0]    q_mod;
    logic [WRAP_W-1:0] r_target;

    // Rounded scale to steps, then drop the factor of eight in 360.
    assign x = X_W'(i_angle) * X_W'(STEPS_PER_REV) + X_W'(180);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= x[X_W-1:3];
        end
    end

    // Quotient by 45 is exact over the whole input range; it stays below
    // twice a revolution, so one subtract takes the remainder.
    assign prod  = PROD_W'(r_y) * PROD_W'(DIV_M);
    assign q     = Q_W'(prod >> DIV_K);
    assign q_mod = (q >= Q_W'(STEPS_PER_REV)) ? q - Q_W'(STEPS_PER_REV) : q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_target <= WRAP_W'(q_mod);
        end
    end

    assign o_target = r_target;

endmodule

// ===== rtl/core/stepper_position_controller.sv =====
// Top level of the stepper position controller: command pipeline, position state and result.
// Depends on spc_pkg and spc_target.
`timescale 1ns / 1ps
// Path: an accepted beat moves through the input register, the goto target register, then
// the result register.
// Throughput: one beat per cycle; the three-stage pipeline stalls as a whole only while a
// result waits on the output. Reset (synchronous, active low) empties the pipeline, sets
// sweep mode going clockwise at position zero, clears the pending move and releases the coils.

module stepper_position_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [spc_pkg::FUNC_W-1:0]          i_func,
    input  logic [spc_pkg::ANGLE_W-1:0]         i_target_angle,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [spc_pkg::STEP_W-1:0]          o_step_taken,
    output logic signed [spc_pkg::POS_W-1:0]    o_position,
    output logic [spc_pkg::WRAP_W-1:0]          o_wrapped_step,
    output logic                                o_coils_on,
    output logic [spc_pkg::MODE_W-1:0]          o_mode_now,
    output logic signed [spc_pkg::PEND_W-1:0]   o_steps_left
);
    import spc_pkg::*;

    // The whole pipeline moves when the output register is empty or being drained.
    logic en;

    logic              r_v1;
    logic [FUNC_W-1:0] r_func1;
    logic              r_v2;
    logic [FUNC_W-1:0] r_func2;
    logic [WRAP_W-1:0] target;

    // Controller state. These registers also serve as the result register: they
    // only change when the next beat reaches the last stage, which needs the
    // output to be free.
    t_mode              r_mode, n_mode;
    logic               r_dir, n_dir;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [WRAP_W-1:0]  r_wrap, n_wrap;
    logic [PEND_W-1:0]  r_pend, n_pend;
    logic               r_coil, n_coil;
    t_step              r_step, n_step;
    logic               r_out_valid;

    // Helpers for the next-state logic.
    logic                    do_cw;
    logic                    do_ccw;
    logic [POS_W-1:0]        pos_inc;
    logic [POS_W-1:0]        pos_dec;
    logic [WRAP_W-1:0]       wrap_inc;
    logic [WRAP_W-1:0]       wrap_dec;
    logic signed [WRAP_W+1:0] g_delta;
    logic signed [WRAP_W+1:0] g_adj;
    logic signed [POS_W:0]    h_delta;
    logic signed [PEND_W-1:0] h_clamped;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Stage one and two: carry the command alongside the target calculation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_func1 <= i_func;
            r_func2 <= r_func1;
        end
    end

    spc_target u_target (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_angle  (i_target_angle),
        .o_target (target)
    );

    // Single steps move the position by one. The position modulo one revolution
    // is tracked alongside it, with a fix-up where the 16-bit count rolls over.
    assign pos_inc  = r_pos + POS_W'(1);
    assign pos_dec  = r_pos - POS_W'(1);
    assign wrap_inc = (r_pos == {1'b0, {(POS_W-1){1'b1}}}) ? WRAP_W'(WRAP_AT_MIN) :
                      (r_wrap == WRAP_W'(STEPS_PER_REV - 1)) ? '0 : r_wrap + WRAP_W'(1);
    assign wrap_dec = (r_pos == {1'b1, {(POS_W-1){1'b0}}}) ? WRAP_W'(WRAP_AT_MAX) :
                      (r_wrap == '0) ? WRAP_W'(STEPS_PER_REV - 1) : r_wrap - WRAP_W'(1);

    // Goto takes the shortest way around the circle.
    assign g_delta = $signed({2'b00, target}) - $signed({2'b00, r_wrap});
    always_comb begin
        if (g_delta > $signed((WRAP_W+2)'(HALF))) begin
            g_adj = g_delta - $signed((WRAP_W+2)'(STEPS_PER_REV));
        end else if (g_delta < -$signed((WRAP_W+2)'(HALF))) begin
            g_adj = g_delta + $signed((WRAP_W+2)'(STEPS_PER_REV));
        end else begin
            g_adj = g_delta;
        end
    end

    // Home heads back to zero, clamped so a far position stops short.
    assign h_delta = -$signed({r_pos[POS_W-1], r_pos});
    always_comb begin
        if (h_delta > $signed((POS_W+1)'(HOME_LIMIT))) begin
            h_clamped = PEND_W'(HOME_LIMIT);
        end else if (h_delta < -$signed((POS_W+1)'(HOME_LIMIT))) begin
            h_clamped = PEND_W'(-HOME_LIMIT);
        end else begin
            h_clamped = PEND_W'(h_delta);
        end
    end

    // Next-state logic for the command in the last stage.
    always_comb begin
        n_mode = r_mode;
        n_dir  = r_dir;
        n_pend = r_pend;
        n_coil = r_coil;
        do_cw  = 1'b0;
        do_ccw = 1'b0;

        case (t_func'(r_func2))
            FUNC_TICK: begin
                case (r_mode)
                    MODE_SCAN: begin
                        if (!r_dir) begin
                            do_cw = 1'b1;
                            if ($signed(pos_inc) >= $signed(POS_W'(SPAN))) begin
                                n_dir = 1'b1;
                            end
                        end else begin
                            do_ccw = 1'b1;
                            if ($signed(pos_dec) <= -$signed(POS_W'(SPAN))) begin
                                n_dir = 1'b0;
                            end
                        end
                    end
                    MODE_SPIN_CW: begin
                        do_cw = 1'b1;
                    end
                    MODE_SPIN_CCW: begin
                        do_ccw = 1'b1;
                    end
                    MODE_MOVE: begin
                        if ($signed(r_pend) > 0) begin
                            do_cw  = 1'b1;
                            n_pend = r_pend - PEND_W'(1);
                        end else if ($signed(r_pend) < 0) begin
                            do_ccw = 1'b1;
                            n_pend = r_pend + PEND_W'(1);
                        end
                        if (n_pend == '0) begin
                            n_mode = MODE_REST;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            FUNC_SWEEP: begin
                n_mode = MODE_SCAN;
                n_dir  = 1'b0;
                n_pend = '0;
            end
            FUNC_STEP_CW: begin
                n_mode = MODE_REST;
                n_pend = '0;
                do_cw  = 1'b1;
            end
            FUNC_STEP_CCW: begin
                n_mode = MODE_REST;
                n_pend = '0;
                do_ccw = 1'b1;
            end
            FUNC_RUN_CW: begin
                n_mode = MODE_SPIN_CW;
                n_pend = '0;
            end
            FUNC_RUN_CCW: begin
                n_mode = MODE_SPIN_CCW;
                n_pend = '0;
            end
            FUNC_GOTO: begin
                n_pend = PEND_W'(g_adj);
                n_mode = (g_adj != '0) ? MODE_MOVE : MODE_REST;
            end
            FUNC_HOME: begin
                n_pend = h_clamped;
                n_mode = (h_clamped != '0) ? MODE_MOVE : MODE_REST;
            end
            FUNC_ZERO: begin
                n_mode = MODE_REST;
                n_pend = '0;
            end
            FUNC_STOP, FUNC_OFF: begin
                n_mode = MODE_REST;
                n_pend = '0;
                n_coil = 1'b0;
            end
            default: begin
            end
        endcase

        // Any step energizes the coils.
        if (do_cw || do_ccw) begin
            n_coil = 1'b1;
        end
    end

    // Position, wrapped position and step code.
    always_comb begin
        n_pos  = r_pos;
        n_wrap = r_wrap;
        n_step = STEP_NONE;
        if (do_cw) begin
            n_pos  = pos_inc;
            n_wrap = wrap_inc;
            n_step = STEP_CW;
        end else if (do_ccw) begin
            n_pos  = pos_dec;
            n_wrap = wrap_dec;
            n_step = STEP_CCW;
        end else if (r_func2 == FUNC_ZERO) begin
            n_pos  = '0;
            n_wrap = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SCAN;
            r_dir       <= 1'b0;
            r_pos       <= '0;
            r_wrap      <= '0;
            r_pend      <= '0;
            r_coil      <= 1'b0;
            r_step      <= STEP_NONE;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v2;
            if (r_v2) begin
                r_mode <= n_mode;
                r_dir  <= n_dir;
                r_pos  <= n_pos;
                r_wrap <= n_wrap;
                r_pend <= n_pend;
                r_coil <= n_coil;
                r_step <= n_step;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_step_taken   = r_step;
    assign o_position     = $signed(r_pos);
    assign o_wrapped_step = r_wrap;
    assign o_coils_on     = r_coil;
    assign o_mode_now     = r_mode;
    assign o_steps_left   = $signed(r_pend);

endmodule

// ===== bench/stepper_position_controller_tb.sv =====
// Self-checking testbench for stepper_position_controller. It runs a directed table
// and random command traffic, with a long stretch of that traffic free of idling.
// Depends on spc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module stepper_position_controller_tb;

    import spc_pkg::*;

    // Codes above FUNC_OFF are spare and must leave the state alone.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = FUNC_W'(FUNC_OFF + 1);
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = '1;

    localparam int IDLE_PCT      = 16;
    localparam int RANDOM_BEATS  = 950;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic [STEP_W-1:0]        step;
        logic signed [POS_W-1:0]  pos;
        logic [WRAP_W-1:0]        wrap;
        logic                     coils;
        logic [MODE_W-1:0]        mode;
        logic signed [PEND_W-1:0] left;
    } motor_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ANGLE_W-1:0] angle;
        logic               fixed;
        motor_result_t      res;
    } plan_row_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [FUNC_W-1:0]         i_func = '0;
    logic [ANGLE_W-1:0]        i_target_angle = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [STEP_W-1:0]         o_step_taken;
    logic signed [POS_W-1:0]   o_position;
    logic [WRAP_W-1:0]         o_wrapped_step;
    logic                      o_coils_on;
    logic [MODE_W-1:0]         o_mode_now;
    logic signed [PEND_W-1:0]  o_steps_left;

    stepper_position_controller u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_target_angle (i_target_angle),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_step_taken   (o_step_taken),
        .o_position     (o_position),
        .o_wrapped_step (o_wrapped_step),
        .o_coils_on     (o_coils_on),
        .o_mode_now     (o_mode_now),
        .o_steps_left   (o_steps_left)
    );

    // Shadow of the controller state, advanced once per accepted command beat.
    t_mode                   mode_q;
    logic                    sweep_ccw_q;
    logic signed [POS_W-1:0] pos_q;
    int                      pend_q;
    logic                    coils_q;

    motor_result_t motor_results_q[$];
    plan_row_t     plan_rows[$];
    int            mismatch_count = 0;
    int            random_beats = 0;
    bit            counting = 1'b0;
    bit            calm = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int wrap_of(logic signed [POS_W-1:0] p);
        int r;
        r = int'(p) % STEPS_PER_REV;
        if (r < 0) begin
            r += STEPS_PER_REV;
        end
        return r;
    endfunction

    function automatic t_step take_step(bit cw);
        pos_q   = cw ? pos_q + 16'sd1 : pos_q - 16'sd1;
        coils_q = 1'b1;
        return cw ? STEP_CW : STEP_CCW;
    endfunction

    function automatic void start_move(int delta);
        pend_q = delta;
        mode_q = (delta != 0) ? MODE_MOVE : MODE_REST;
    endfunction

    // Applies one command to the shadow state and returns what the block should answer.
    function automatic motor_result_t advance_motor(logic [FUNC_W-1:0] f,
                                                    logic [ANGLE_W-1:0] ang);
        motor_result_t r;
        int            target;
        int            delta;
        r.step = STEP_NONE;
        case (f)
            FUNC_TICK: begin
                case (mode_q)
                    MODE_SCAN: begin
                        if (!sweep_ccw_q) begin
                            r.step = take_step(1'b1);
                            if (int'(pos_q) >= SPAN) sweep_ccw_q = 1'b1;
                        end else begin
                            r.step = take_step(1'b0);
                            if (int'(pos_q) <= -SPAN) sweep_ccw_q = 1'b0;
                        end
                    end
                    MODE_SPIN_CW:  r.step = take_step(1'b1);
                    MODE_SPIN_CCW: r.step = take_step(1'b0);
                    MODE_MOVE: begin
                        if (pend_q > 0) begin
                            r.step = take_step(1'b1);
                            pend_q--;
                        end else if (pend_q < 0) begin
                            r.step = take_step(1'b0);
                            pend_q++;
                        end
                        if (pend_q == 0) mode_q = MODE_REST;
                    end
                    default: ;
                endcase
            end
            FUNC_SWEEP: begin
                mode_q      = MODE_SCAN;
                sweep_ccw_q = 1'b0;
                pend_q      = 0;
            end
            FUNC_STEP_CW, FUNC_STEP_CCW: begin
                mode_q = MODE_REST;
                pend_q = 0;
                r.step = take_step(f == FUNC_STEP_CW);
            end
            FUNC_RUN_CW: begin
                mode_q = MODE_SPIN_CW;
                pend_q = 0;
            end
            FUNC_RUN_CCW: begin
                mode_q = MODE_SPIN_CCW;
                pend_q = 0;
            end
            FUNC_GOTO: begin
                // Round the angle to the nearest step, then take the short way round.
                target = ((int'(ang) * STEPS_PER_REV + 180) / 360) % STEPS_PER_REV;
                delta  = target - wrap_of(pos_q);
                if (delta > HALF) delta -= STEPS_PER_REV;
                else if (delta < -HALF) delta += STEPS_PER_REV;
                start_move(delta);
            end
            FUNC_HOME: begin
                delta = -int'(pos_q);
                if (delta > HOME_LIMIT) delta = HOME_LIMIT;
                if (delta < -HOME_LIMIT) delta = -HOME_LIMIT;
                start_move(delta);
            end
            FUNC_ZERO: begin
                mode_q = MODE_REST;
                pend_q = 0;
                pos_q  = '0;
            end
            FUNC_STOP, FUNC_OFF: begin
                mode_q  = MODE_REST;
                pend_q  = 0;
                coils_q = 1'b0;
            end
            default: ;
        endcase
        r.pos   = pos_q;
        r.wrap  = WRAP_W'(wrap_of(pos_q));
        r.coils = coils_q;
        r.mode  = mode_q;
        r.left  = PEND_W'(pend_q);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Compares the result beat on the output with the oldest pending expectation.
    task automatic check_result();
        motor_result_t e;
        if (motor_results_q.size() == 0) begin
            report_mismatch("result beat arrived with nothing expected");
            return;
        end
        e = motor_results_q.pop_front();
        if (o_step_taken !== e.step)
            report_mismatch($sformatf("step_taken %0d, expected %0d", o_step_taken, e.step));
        if (o_position !== e.pos)
            report_mismatch($sformatf("position %0d, expected %0d", o_position, e.pos));
        if (o_wrapped_step !== e.wrap)
            report_mismatch($sformatf("wrapped_step %0d, expected %0d",
                                      o_wrapped_step, e.wrap));
        if (o_coils_on !== e.coils)
            report_mismatch($sformatf("coils_on %0d, expected %0d", o_coils_on, e.coils));
        if (o_mode_now !== e.mode)
            report_mismatch($sformatf("mode_now %0d, expected %0d", o_mode_now, e.mode));
        if (o_steps_left !== e.left)
            report_mismatch($sformatf("steps_left %0d, expected %0d", o_steps_left, e.left));
    endtask

    // Result side: sample at the edge, then decide whether to stall the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_result();
        end
        i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Presents one command beat, holds it until accepted, records the expected result,
    // then may idle at random before returning. A fixed expectation replaces the predicted one.
    task automatic send_beat(logic [FUNC_W-1:0] f, logic [ANGLE_W-1:0] a,
                             logic fixed, motor_result_t fixed_res);
        motor_result_t r;
        i_in_valid     <= 1'b1;
        i_func         <= f;
        i_target_angle <= a;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = advance_motor(f, a);
        motor_results_q.push_back(fixed ? fixed_res : r);
        if (counting && f <= FUNC_OFF) random_beats++;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic beat(logic [FUNC_W-1:0] f);
        send_beat(f, ANGLE_W'($urandom_range(511)), 1'b0, '0);
    endtask

    task automatic ticks(int n);
        repeat (n) beat(FUNC_TICK);
    endtask

    // Ticks until a goto or home move finishes, sometimes cutting it short.
    task automatic finish_move();
        int cap;
        int n;
        cap = ($urandom_range(99) < 20) ? $urandom_range(20) : HOME_LIMIT + 10;
        n   = 0;
        while (mode_q == MODE_MOVE && n < cap) begin
            beat(FUNC_TICK);
            n++;
        end
    endtask

    function automatic void plan(logic [FUNC_W-1:0] f, logic [ANGLE_W-1:0] a);
        plan_rows.push_back('{f, a, 1'b0, '0});
    endfunction

    function automatic void plan_fixed(logic [FUNC_W-1:0] f, logic [ANGLE_W-1:0] a,
                                       t_step step, int pos, int wrap, bit coils,
                                       t_mode mode, int left);
        motor_result_t r;
        r = '{step, POS_W'(pos), WRAP_W'(wrap), coils, mode, PEND_W'(left)};
        plan_rows.push_back('{f, a, 1'b1, r});
    endfunction

    // Mostly well-formed command sequences with random content, plus some noise.
    task automatic random_traffic(int goal);
        int roll;
        while (random_beats < goal) begin
            roll = $urandom_range(99);
            if (roll < 15) begin
                beat(FUNC_SWEEP);
                ticks($urandom_range(250, 1));
            end else if (roll < 30) begin
                beat($urandom_range(1) ? FUNC_RUN_CW : FUNC_RUN_CCW);
                ticks($urandom_range(40, 1));
            end else if (roll < 50) begin
                send_beat(FUNC_GOTO, ($urandom_range(99) < 80) ? ANGLE_W'($urandom_range(359))
                                                               : ANGLE_W'($urandom_range(511)),
                          1'b0, '0);
                finish_move();
            end else if (roll < 60) begin
                beat(FUNC_HOME);
                finish_move();
            end else if (roll < 75) begin
                repeat ($urandom_range(5, 1)) begin
                    beat($urandom_range(1) ? FUNC_STEP_CW : FUNC_STEP_CCW);
                end
            end else if (roll < 82) begin
                case ($urandom_range(2))
                    0:       beat(FUNC_ZERO);
                    1:       beat(FUNC_STOP);
                    default: beat(FUNC_OFF);
                endcase
            end else begin
                beat(FUNC_W'($urandom_range(15)));
            end
        end
    endtask

    initial begin
        int drain;
        mode_q      = MODE_SCAN;
        sweep_ccw_q = 1'b0;
        pos_q       = '0;
        pend_q      = 0;
        coils_q     = 1'b0;

        // Directed table. Rows with a typed result follow straight from reset state.
        plan_fixed(FUNC_SPARE_FIRST, '0, STEP_NONE, 0, 0, 1'b0, MODE_SCAN, 0);
        plan_fixed(FUNC_TICK, '0, STEP_CW, 1, 1, 1'b1, MODE_SCAN, 0);
        plan_fixed(FUNC_ZERO, '1, STEP_NONE, 0, 0, 1'b1, MODE_REST, 0);
        plan_fixed(FUNC_TICK, '0, STEP_NONE, 0, 0, 1'b1, MODE_REST, 0);
        plan_fixed(FUNC_STEP_CCW, '0, STEP_CCW, -1, STEPS_PER_REV - 1, 1'b1, MODE_REST, 0);
        plan_fixed(FUNC_HOME, '0, STEP_NONE, -1, STEPS_PER_REV - 1, 1'b1, MODE_MOVE, 1);
        plan_fixed(FUNC_TICK, '0, STEP_CW, 0, 0, 1'b1, MODE_REST, 0);
        plan_fixed(FUNC_GOTO, 9'd359, STEP_NONE, 0, 0, 1'b1, MODE_MOVE, -1);
        plan(FUNC_TICK, '0);
        plan(FUNC_GOTO, '1);          // largest angle, far outside one turn
        plan(FUNC_TICK, '0);
        plan(FUNC_GOTO, 9'd360);      // exactly one full turn
        plan(FUNC_GOTO, 9'd180);      // exactly half a turn away
        plan_fixed(FUNC_STOP, '0, STEP_NONE, 0, 0, 1'b0, MODE_REST, 0);
        plan(FUNC_RUN_CW, '0);
        plan(FUNC_TICK, '0);
        plan(FUNC_TICK, '0);
        plan(FUNC_RUN_CCW, '0);
        plan(FUNC_TICK, '0);
        plan(FUNC_TICK, '0);
        plan(FUNC_TICK, '0);
        plan_fixed(FUNC_OFF, '0, STEP_NONE, -1, STEPS_PER_REV - 1, 1'b0, MODE_REST, 0);
        plan(FUNC_SWEEP, '0);
        plan(FUNC_TICK, '0);
        plan(FUNC_STEP_CW, '0);
        plan(FUNC_SPARE_LAST, '1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_rows[i]) begin
            send_beat(plan_rows[i].func, plan_rows[i].angle, plan_rows[i].fixed,
                      plan_rows[i].res);
        end

        counting = 1'b1;
        random_traffic(RANDOM_BEATS / 3);

        // Long stretch with no idling on either side.
        calm = 1'b1;
        random_traffic(2 * RANDOM_BEATS / 3);
        calm = 1'b0;

        random_traffic(RANDOM_BEATS);

        i_in_valid <= 1'b0;

        drain = 0;
        while (motor_results_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (motor_results_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      motor_results_q.size()));
        end

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
